// File: rtl/mwc_pkg.sv
`timescale 1ns / 1ps

package mwc_pkg;

    // request codes
    localparam logic REQ_DRAW   = 1'b0;
    localparam logic REQ_RESEED = 1'b1;

    // generator multipliers and reset state
    localparam logic [15:0] MUL_Z   = 16'd36969;
    localparam logic [15:0] MUL_W   = 16'd18000;
    localparam logic [31:0] RESET_Z = 32'd362436069;
    localparam logic [31:0] RESET_W = 32'd521288629;

    // front -> back: one classified request
    typedef struct packed {
        logic        draw;      // 0: reseed, result is all zero
        logic [31:0] raw;       // generator word after the update
        logic [31:0] lo;        // smaller bound
        logic [31:0] span_m1;   // |a - b|, span minus one
    } mid_item_t;

    // back -> result queue
    typedef struct packed {
        logic [31:0] ranged_value;
        logic [31:0] raw_word;
    } out_item_t;

endpackage

// File: rtl/mwc_queue.sv
`timescale 1ns / 1ps

module mwc_queue
#(
    parameter int W     = 8,
    parameter int DEPTH = 2
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [W-1:0]                   wr_data,
    input  logic                           rd_en,
    output logic [W-1:0]                   rd_data,
    output logic                           full,
    output logic                           empty,
    output logic [$clog2(DEPTH+1)-1:0]     count
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [W-1:0]     mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rd_data = mem[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_wr, do_rd})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// File: rtl/mwc_front.sv
`timescale 1ns / 1ps

module mwc_front
    import mwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  logic        req_type,
    input  logic [63:0] seed,
    input  logic [31:0] bound_a,
    input  logic [31:0] bound_b,
    output mid_item_t   item
);

    logic [31:0] z_reg, z_next;
    logic [31:0] w_reg, w_next;
    logic [31:0] z_adv, w_adv, raw;
    logic        a_lt_b;

    // one MWC step per half; max 36970 * 65535 fits in 32 bits
    assign z_adv = {16'b0, MUL_Z} * {16'b0, z_reg[15:0]} + {16'b0, z_reg[31:16]};
    assign w_adv = {16'b0, MUL_W} * {16'b0, w_reg[15:0]} + {16'b0, w_reg[31:16]};
    assign raw   = {z_adv[15:0], 16'b0} + w_adv;

    always_comb
    begin
        z_next = z_reg;
        w_next = w_reg;
        if (accept)
        begin
            if (req_type == REQ_DRAW)
            begin
                z_next = z_adv;
                w_next = w_adv;
            end
            else if (seed != '0)
            begin
                z_next = seed[31:0];
                w_next = seed[63:32];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_reg <= RESET_Z;
            w_reg <= RESET_W;
        end
        else
        begin
            z_reg <= z_next;
            w_reg <= w_next;
        end
    end

    // bounds may come in either order
    assign a_lt_b       = (bound_a < bound_b);
    assign item.draw    = (req_type == REQ_DRAW);
    assign item.raw     = raw;
    assign item.lo      = a_lt_b ? bound_a : bound_b;
    assign item.span_m1 = a_lt_b ? (bound_b - bound_a) : (bound_a - bound_b);

endmodule

// File: rtl/mwc_back.sv
`timescale 1ns / 1ps

module mwc_back
    import mwc_pkg::*;
#(
    parameter int OUT_DEPTH = 4
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  mid_item_t                        item,
    input  logic                             mid_empty,
    output logic                             mid_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0]   out_count,
    output logic                             out_push,
    output out_item_t                        out_data
);

    localparam int CNT_W = $clog2(OUT_DEPTH+1);
    localparam int SUM_W = CNT_W + 1;

    // stage 1: span_m1 * raw
    logic        v1_reg;
    logic        draw1_reg;
    logic [31:0] raw1_reg, lo1_reg;
    logic [63:0] prod1_reg;
    // stage 2: floor((span_m1 + 1) * raw / 2^32)
    logic        v2_reg;
    logic        draw2_reg;
    logic [31:0] raw2_reg, lo2_reg, hi2_reg;

    logic [63:0]      prod_full;
    logic [SUM_W-1:0] used;

    // credit: result slots taken plus items still in the pipe
    assign used    = SUM_W'(out_count) + SUM_W'(v1_reg) + SUM_W'(v2_reg);
    assign mid_pop = !mid_empty && (used < SUM_W'(OUT_DEPTH));

    // (span_m1 + 1) * raw = span_m1 * raw + raw, stays below 2^64
    assign prod_full = prod1_reg + {32'b0, raw1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= mid_pop;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        draw1_reg <= item.draw;
        raw1_reg  <= item.raw;
        lo1_reg   <= item.lo;
        prod1_reg <= {32'b0, item.span_m1} * {32'b0, item.raw};

        draw2_reg <= draw1_reg;
        raw2_reg  <= raw1_reg;
        lo2_reg   <= lo1_reg;
        hi2_reg   <= prod_full[63:32];
    end

    assign out_push              = v2_reg;
    assign out_data.ranged_value = draw2_reg ? (lo2_reg + hi2_reg) : '0;
    assign out_data.raw_word     = draw2_reg ? raw2_reg : '0;

endmodule

// File: rtl/mwc_random_in_range.sv
`timescale 1ns / 1ps

// Dual multiply-with-carry random generator with range mapping. Each request
// pushed in gives exactly one result, in order. A draw request (req_type 0)
// advances both generator halves, z = 36969*z[15:0] + z[31:16] and
// w = 18000*w[15:0] + w[31:16], returns raw_word = (z << 16) + w and
// ranged_value = lo + floor(span * raw_word / 2^32), where lo is the smaller
// of bound_a and bound_b and span = |bound_a - bound_b| + 1 (up to 2^32, so a
// full-range request returns raw_word itself). A reseed request (req_type 1)
// with a nonzero seed loads w from seed[63:32] and z from seed[31:0]; a zero
// seed leaves the state alone. A reseed result reads zero on both ports.
// Rate: one request per cycle sustained while results are popped, set by the
// front stage, which does the generator update in the cycle the request is
// accepted. An accepted request goes through the middle queue, then the 32x32
// range multiply and the high-word add each take a registered stage, before
// its result enters the result queue. The back end only takes a request from
// the middle queue when the result queue has room for everything in flight,
// so a stalled consumer fills the result queue (OUT_DEPTH), then the middle
// queue (MID_DEPTH), and only then raises full. OUT_DEPTH below 4 still works
// but lowers the sustained rate.

module mwc_random_in_range
    import mwc_pkg::*;
#(
    parameter int MID_DEPTH = 2,
    parameter int OUT_DEPTH = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    // request side
    input  logic        push,
    output logic        full,
    input  logic        req_type,
    input  logic [63:0] seed,
    input  logic [31:0] bound_a,
    input  logic [31:0] bound_b,
    // result side
    output logic        empty,
    input  logic        pop,
    output logic [31:0] ranged_value,
    output logic [31:0] raw_word
);

    localparam int MID_W     = $bits(mid_item_t);
    localparam int OUT_W     = $bits(out_item_t);
    localparam int MID_CNT_W = $clog2(MID_DEPTH+1);
    localparam int OUT_CNT_W = $clog2(OUT_DEPTH+1);

    logic                 accept;
    mid_item_t            front_item;
    mid_item_t            back_item;
    logic [MID_W-1:0]     mid_rd_data;
    logic                 mid_empty;
    logic                 mid_pop;
    logic [MID_CNT_W-1:0] mid_count;
    logic                 out_push;
    out_item_t            out_wr_item;
    logic [OUT_W-1:0]     out_rd_data;
    out_item_t            out_rd_item;
    logic [OUT_CNT_W-1:0] out_count;
    logic                 out_full;

    assign accept = push && !full;

    // front: generator state, classify request, order the bounds
    mwc_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .req_type (req_type),
        .seed     (seed),
        .bound_a  (bound_a),
        .bound_b  (bound_b),
        .item     (front_item)
    );

    // middle queue decouples front from back
    mwc_queue
    #(
        .W     (MID_W),
        .DEPTH (MID_DEPTH)
    )
    u_mid_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_item),
        .rd_en   (mid_pop),
        .rd_data (mid_rd_data),
        .full    (full),
        .empty   (mid_empty),
        .count   (mid_count)
    );

    assign back_item = mid_item_t'(mid_rd_data);

    // back: range mapping pipeline with credit to the result queue
    mwc_back
    #(
        .OUT_DEPTH (OUT_DEPTH)
    )
    u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (back_item),
        .mid_empty (mid_empty || (mid_count == '0)),
        .mid_pop   (mid_pop),
        .out_count (out_count),
        .out_push  (out_push),
        .out_data  (out_wr_item)
    );

    // result queue; never overflows thanks to the credit check in the back end
    mwc_queue
    #(
        .W     (OUT_W),
        .DEPTH (OUT_DEPTH)
    )
    u_out_q
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (out_push),
        .wr_data (out_wr_item),
        .rd_en   (pop),
        .rd_data (out_rd_data),
        .full    (out_full),
        .empty   (empty),
        .count   (out_count)
    );

    assign out_rd_item  = out_item_t'(out_rd_data);
    assign ranged_value = out_rd_item.ranged_value;
    assign raw_word     = out_rd_item.raw_word & {32{!out_full || !empty}};

endmodule

// File: rtl/mwc_checker.sv
`timescale 1ns / 1ps

module mwc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [31:0] ranged_value,
    input logic [31:0] raw_word
);

    // queues come out of reset empty on both sides
    assert property (@(posedge clk) !rst_n |-> (empty && !full))
        else $error("queue status wrong during reset");

    // a waiting result that is not taken stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(ranged_value) && $stable(raw_word)))
        else $error("stalled result changed");

    // the request side can only fill up by taking a request
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a request");

    // the result side backs up before the request side does
    assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !empty)
        else $error("full with no result waiting");

endmodule

bind mwc_random_in_range mwc_checker u_mwc_checker (.*);

// File: tb/sv/mwc_random_in_range_tb.sv
`timescale 1ns / 1ps

// Self-checking bench for the dual multiply-with-carry range generator.
// Requests go in through the push/full queue port, results come out through
// the empty/pop queue port. A local predictor tracks both generator halves
// and queues the expected result for each accepted request; a separate
// process pops results and compares them against the oldest expectation.

module mwc_random_in_range_tb;
    import mwc_pkg::*;

    localparam real CLK_PERIOD   = 12.0;
    localparam int  RESET_CYCLES = 10;
    localparam int  RANDOM_REQS  = 650;
    localparam int  STREAM_REQS  = 80;
    localparam int  PRESSURE_REQS = 30;
    localparam int  HOLD_OFF_CYCLES = 300;
    localparam int  SETTLE_CYCLES = 8;     // slack for the pipeline to drain

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    logic        req_type;
    logic [63:0] seed;
    logic [31:0] bound_a;
    logic [31:0] bound_b;
    logic        empty;
    logic        pop;
    logic [31:0] ranged_value;
    logic [31:0] raw_word;

    // predictor copy of the generator halves
    logic [31:0] gen_z;
    logic [31:0] gen_w;

    // expected results, oldest first
    out_item_t   expected_results[$];
    int          mismatch_count;

    // idle controls shared between the stimulus and the result side
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          hold_off_request;   // set by a test, consumed by the popper

    mwc_random_in_range uut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .seed         (seed),
        .bound_a      (bound_a),
        .bound_b      (bound_b),
        .empty        (empty),
        .pop          (pop),
        .ranged_value (ranged_value),
        .raw_word     (raw_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2.0) clk = ~clk;
    end

    // Hard stop, set well beyond the slowest legit run (every request waiting
    // out a long gap on both sides plus the hold-off).
    initial
    begin
        #5_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // Gap length for either side: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Bound values biased toward the edges and the midpoint of the 32-bit range.
    function automatic logic [31:0] pick_bound();
        case ($urandom_range(0, 7))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'(($urandom_range(0, 15)));
            3:       return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
            4:       return 32'h8000_0000 ^ 32'($urandom_range(0, 3));
            default: return $urandom;
        endcase
    endfunction

    // Advance the model by one accepted request and queue what it should return.
    // Draw: both halves step, raw = (z << 16) + w, ranged = lo + (span*raw >> 32)
    // with span = hi - lo + 1 kept at 33 bits so the full range maps to raw.
    task automatic predict_request(input logic rt, input logic [63:0] sd,
                                   input logic [31:0] a, input logic [31:0] b);
        out_item_t   res;
        logic [31:0] lo;
        logic [31:0] hi;
        logic [32:0] span;
        logic [63:0] product;
        logic [31:0] raw;
        res = '0;
        if (rt == REQ_RESEED)
        begin
            // zero seed is a no-op on the state; result reads zero either way
            if (sd != 64'd0)
            begin
                gen_w = sd[63:32];
                gen_z = sd[31:0];
            end
        end
        else
        begin
            gen_z = 32'(MUL_Z) * 32'(gen_z[15:0]) + 32'(gen_z[31:16]);
            gen_w = 32'(MUL_W) * 32'(gen_w[15:0]) + 32'(gen_w[31:16]);
            raw = {gen_z[15:0], 16'h0000} + gen_w;
            lo = (a < b) ? a : b;
            hi = (a < b) ? b : a;
            span = 33'(hi - lo) + 33'd1;
            product = 64'(span) * 64'(raw);
            res.ranged_value = lo + product[63:32];
            res.raw_word = raw;
        end
        expected_results.push_back(res);
    endtask

    // Offer one request and hold it until the block takes it. push is left high
    // afterwards so back-to-back requests never drop it for a cycle.
    task automatic send_request(input logic rt, input logic [63:0] sd,
                                input logic [31:0] a, input logic [31:0] b);
        int gap;
        gap = tx_idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        @(negedge clk);
        push     <= 1'b1;
        req_type <= rt;
        seed     <= sd;
        bound_a  <= a;
        bound_b  <= b;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        predict_request(rt, sd, a, b);
    endtask

    task automatic send_draw(input logic [31:0] a, input logic [31:0] b);
        send_request(REQ_DRAW, {$urandom, $urandom}, a, b);
    endtask

    task automatic send_random_request();
        logic [63:0] sd;
        logic [31:0] a;
        logic [31:0] b;
        sd = {$urandom, $urandom};
        a  = pick_bound();
        b  = ($urandom_range(0, 9) == 0) ? a : pick_bound();
        if ($urandom_range(0, 11) == 0)
        begin
            // reseed now and then, a few of them with a zero seed
            if ($urandom_range(0, 3) == 0)
                sd = 64'd0;
            send_request(REQ_RESEED, sd, a, b);
        end
        else
            send_request(REQ_DRAW, sd, a, b);
    endtask

    task automatic drop_push();
        @(negedge clk);
        push <= 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Result side: pop with random stalls, take a long hold-off when a test
    // asks for one, and check every popped result against the oldest expectation.
    initial
    begin : result_checker
        int        stall_left;
        out_item_t want;
        stall_left = 0;
        pop = 1'b0;
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("result with nothing expected: ranged_value %h raw_word %h",
                           ranged_value, raw_word);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (ranged_value !== want.ranged_value)
                    begin
                        $error("ranged_value: expected %h, actual %h",
                               want.ranged_value, ranged_value);
                        mismatch_count++;
                    end
                    if (raw_word !== want.raw_word)
                    begin
                        $error("raw_word: expected %h, actual %h",
                               want.raw_word, raw_word);
                        mismatch_count++;
                    end
                end
            end
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                stall_left = hold_off_request;
                hold_off_request = 0;
            end
            else if (stall_left == 0 && rx_idle_on)
                stall_left = pick_gap();
            if (stall_left > 0)
            begin
                pop <= 1'b0;
                stall_left--;
            end
            else
                pop <= 1'b1;
        end
    end

    // Edges of the bounds, both orders, equal bounds, full range, and the
    // reseed corners: zero seed, one word zero, all ones, plus a draw that
    // carries a nonzero seed the block must ignore.
    task automatic test_directed();
        send_draw(32'h0000_0000, 32'hFFFF_FFFF);        // full range
        send_draw(32'hFFFF_FFFF, 32'h0000_0000);        // full range, reversed
        send_draw(32'h0000_0000, 32'h0000_0000);
        send_draw(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_draw(32'h1234_5678, 32'h1234_5678);
        send_draw(32'h0000_0064, 32'h0000_000A);        // min above max
        send_draw(32'h0000_000A, 32'h0000_0064);
        send_draw(32'h0000_0000, 32'h0000_0001);
        send_draw(32'hFFFF_FFFE, 32'hFFFF_FFFF);
        send_draw(32'h0000_0001, 32'hFFFF_FFFF);
        send_request(REQ_RESEED, 64'd0, 32'hFFFF_FFFF, 32'h0000_0000);
        send_draw(32'h0000_0000, 32'h7FFF_FFFF);
        send_request(REQ_RESEED, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 32'h0);
        send_draw(32'h0000_0000, 32'hFFFF_FFFF);
        send_draw(32'h8000_0000, 32'h7FFF_FFFF);
        send_request(REQ_RESEED, 64'hDEAD_BEEF_0000_0000, $urandom, $urandom);
        send_draw(32'h0000_0000, 32'hFFFF_FFFF);
        send_draw(32'h0000_0010, 32'h0000_0020);
        send_request(REQ_RESEED, 64'h0000_0000_CAFE_F00D, $urandom, $urandom);
        send_draw(32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_DRAW, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0000_0005, 32'h0000_0003);
        send_request(REQ_RESEED, {$urandom, $urandom}, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_draw(32'h0000_0000, 32'hFFFF_FFFF);
        drop_push();
        wait_drained();
    endtask

    // Bulk mix of draws and reseeds with random gaps on both sides.
    task automatic test_random_mix();
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        repeat (RANDOM_REQS) send_random_request();
        drop_push();
        wait_drained();
    endtask

    // No idling anywhere: one request per cycle in and out.
    task automatic test_streaming();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
        repeat (STREAM_REQS) send_random_request();
        drop_push();
        wait_drained();
    endtask

    // Consumer stops for a long stretch while requests keep coming, so the
    // result queue and the middle queue fill and full has to hold the sender.
    task automatic test_backpressure();
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b1;
        @(posedge clk);
        hold_off_request = HOLD_OFF_CYCLES;
        repeat (PRESSURE_REQS) send_random_request();
        drop_push();
        wait_drained();
    endtask

    initial
    begin
        push     = 1'b0;
        req_type = REQ_DRAW;
        seed     = 64'd0;
        bound_a  = 32'd0;
        bound_b  = 32'd0;
        rst_n    = 1'b0;
        gen_z    = RESET_Z;
        gen_w    = RESET_W;
        mismatch_count   = 0;
        tx_idle_on       = 1'b1;
        rx_idle_on       = 1'b1;
        hold_off_request = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_directed();
        test_backpressure();
        test_random_mix();
        test_streaming();
        test_backpressure();

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
